@@ rtl/ragt_pkg.sv @@
// Package: shared types and codes for the recorder admission gap tracker
`timescale 1ns / 1ps
`default_nettype none
package ragt_pkg;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          RES_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_UNBOUND  = 2'd0,
        ST_ACTIVE   = 2'd1,
        ST_DEGRADED = 2'd2,
        ST_FAILED   = 2'd3
    } link_state_t;

    typedef enum logic [2:0] {
        MODE_ADMIT   = 3'd0,
        MODE_LEASE   = 3'd1,
        MODE_RECFAIL = 3'd2,
        MODE_RECOVER = 3'd3,
        MODE_UNBIND  = 3'd4,
        MODE_REBIND  = 3'd5,
        MODE_METRICS = 3'd6,
        MODE_SPARE   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        TOPO_STRONG   = 2'd0,
        TOPO_ISOLATED = 2'd1,
        TOPO_BEST     = 2'd2,
        TOPO_SPARE    = 2'd3
    } topo_t;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_GAP    = 2'd1;
    localparam logic [1:0] KIND_METRIC = 2'd2;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INVALID  = 3'd1;
    localparam logic [2:0] STS_EXHAUST  = 3'd2;
    localparam logic [2:0] STS_UNAVAIL  = 3'd3;
    localparam logic [2:0] STS_BLOCK    = 3'd4;
    localparam logic [2:0] STS_DEGRADED = 3'd5;

    localparam logic [2:0] OC_RECORD = 3'd0;
    localparam logic [2:0] OC_DROP   = 3'd1;
    localparam logic [2:0] OC_BLOCK  = 3'd2;
    localparam logic [2:0] OC_FAIL   = 3'd3;
    localparam logic [2:0] OC_BYPASS = 3'd4;
    localparam logic [2:0] OC_NONE   = 3'd5;

    localparam logic [2:0] CA_READY    = 3'd0;
    localparam logic [2:0] CA_RECFAIL  = 3'd1;
    localparam logic [2:0] CA_DEGRADED = 3'd2;
    localparam logic [2:0] CA_LAG      = 3'd3;
    localparam logic [2:0] CA_FULL     = 3'd4;
    localparam logic [2:0] CA_UNBOUND  = 3'd5;

    localparam logic [1:0] REG_TOPOLOGY = 2'd0;
    localparam logic [1:0] REG_FAILFULL = 2'd1;
    localparam logic [1:0] REG_CURSOR   = 2'd2;
    localparam logic [1:0] REG_TIME     = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [2:0]  outcome;
        logic [2:0]  cause;
        logic [63:0] cur_old;
        logic [63:0] cur_new;
        logic [63:0] tag;
        logic [63:0] first_value;
        logic [63:0] end_value;
        logic [2:0]  gap_cause;
        logic        last;
    } result_t;

    function automatic logic impaired_state(input link_state_t s);
        impaired_state = (s == ST_DEGRADED) || (s == ST_FAILED);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        sat_add = sum[64] ? ONES : sum[63:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/recorder_admission_gap_tracker_unit.sv @@
// Top level: recorder admission gap tracker with stream ports and register port
//
// Usage: items enter on the s_ group (s_tuser = mode, s_tdata = time, cursor,
// sink flag). Each item is registered, then decided by combinational logic that
// reads the link state, expected cursor and counters; its one to four results
// go into a four-entry result buffer and leave on the m_ group one transfer a
// cycle while m_tready is high, the final result of an item marked by m_tlast.
// Throughput: one item a cycle for items with one result while m_tready is high;
// an item with more results holds the decision stage until its last result
// leaves through the single result port.
// A stalled receiver (m_tready low) holds the result buffer; the input
// register then fills and s_tready drops, so nothing is lost.
// Registers are to be written through the APB port only while idle; the block
// does not enforce this. Writing the start cursor or start time also loads
// the expected cursor or last time.
// Reset: link state active, counters and debt number zero, buffers empty.
`timescale 1ns / 1ps
`default_nettype none
module recorder_admission_gap_tracker_unit
    import ragt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // now_time[63:0], offered_cursor[127:64],
                                         // sink_full[128], zero pad
    input  wire logic [2:0]   s_tuser,   // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [335:0]      m_tdata,   // status, outcome, cause, prior cursor,
                                         // new cursor, tag, first_value,
                                         // end_value, gap_cause, zero pad
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    // configuration
    logic [1:0]  topology_reg;
    logic        fail_full_reg;
    logic [63:0] start_cursor_reg;
    logic [63:0] start_time_reg;
    logic        cfg_wr;

    // path state
    link_state_t link_reg, link_next;
    logic [63:0] exp_reg, exp_next;
    logic [63:0] last_time_reg, last_time_next;
    logic [63:0] debt_reg, debt_next;
    logic [63:0] dropped_reg, dropped_next;
    logic [63:0] gaps_reg, gaps_next;
    logic [63:0] blocked_reg, blocked_next;
    logic [63:0] imp_total_reg, imp_total_next;
    logic        imp_open_reg, imp_open_next;
    logic [63:0] imp_since_reg, imp_since_next;

    // input register
    logic        in_vld_reg;
    mode_t       in_mode_reg;
    logic [63:0] in_now_reg;
    logic [63:0] in_cur_reg;
    logic        in_full_reg;

    // result buffer
    result_t     res_reg [RES_DEPTH];
    result_t     res_next [RES_DEPTH];
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg;

    logic        pop;
    logic        consume;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register read
    always_comb
    begin
        unique case (paddr[4:3])
            REG_TOPOLOGY: prdata = {62'd0, topology_reg};
            REG_FAILFULL: prdata = {63'd0, fail_full_reg};
            REG_CURSOR:   prdata = start_cursor_reg;
            REG_TIME:     prdata = start_time_reg;
            default:      prdata = 64'd0;
        endcase
    end

    // handshake
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign consume  = in_vld_reg && ((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && pop));
    assign s_tready = !in_vld_reg || consume;

    assign m_tuser  = res_reg[idx_reg].kind;
    assign m_tlast  = res_reg[idx_reg].last;
    assign m_tdata  = {4'd0,
                       res_reg[idx_reg].gap_cause,
                       res_reg[idx_reg].end_value,
                       res_reg[idx_reg].first_value,
                       res_reg[idx_reg].tag,
                       res_reg[idx_reg].cur_new,
                       res_reg[idx_reg].cur_old,
                       res_reg[idx_reg].cause,
                       res_reg[idx_reg].outcome,
                       res_reg[idx_reg].status};

    // decision logic
    always_comb
    begin
        logic        ok;
        logic        unavail;
        link_state_t tgt;
        logic [63:0] after;
        logic [2:0]  st;
        logic [2:0]  oc;
        logic [2:0]  ca;
        logic [2:0]  base;
        logic [63:0] span;
        logic        g0_on;
        logic        g1_on;
        logic [63:0] g0_first, g0_end, g1_first, g1_end;
        logic [2:0]  g0_cause, g1_cause;
        logic [63:0] id1;
        logic [65:0] drop_sum;
        logic [1:0]  ngap;
        logic [64:0] gap_sum;

        link_next      = link_reg;
        exp_next       = exp_reg;
        last_time_next = last_time_reg;
        debt_next      = debt_reg;
        dropped_next   = dropped_reg;
        gaps_next      = gaps_reg;
        blocked_next   = blocked_reg;
        imp_total_next = imp_total_reg;
        imp_open_next  = imp_open_reg;
        imp_since_next = imp_since_reg;
        cnt_next       = 3'd1;
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_next[i] = '0;
        end

        tgt      = link_reg;
        after    = in_cur_reg + 64'd1;
        st       = STS_OK;
        oc       = OC_RECORD;
        ca       = CA_READY;
        unavail  = 1'b0;
        base     = (topology_reg == TOPO_ISOLATED) ? 3'd0 : 3'd3;
        g0_on    = 1'b0;
        g1_on    = 1'b0;
        g0_first = exp_reg;
        g0_end   = in_cur_reg;
        g0_cause = base + 3'd1;
        g1_first = in_cur_reg;
        g1_end   = in_cur_reg + 64'd1;
        g1_cause = base + 3'd2;
        id1      = 64'd0;
        drop_sum = 66'd0;
        ngap     = 2'd0;
        gap_sum  = 65'd0;
        span     = (in_now_reg >= imp_since_reg) ? (in_now_reg - imp_since_reg) : 64'd0;

        // validate
        ok = (in_now_reg >= last_time_reg);
        unique case (in_mode_reg)
            MODE_ADMIT:   ok = ok && (in_cur_reg != ONES) && (in_cur_reg >= exp_reg);
            MODE_LEASE, MODE_RECFAIL, MODE_UNBIND:
                          ok = ok && (link_reg != ST_UNBOUND);
            MODE_RECOVER: ok = ok && impaired_state(link_reg);
            MODE_REBIND:  ok = ok && (link_reg == ST_UNBOUND) && (in_cur_reg != ONES);
            MODE_METRICS: ok = ok;
            default:      ok = 1'b0;
        endcase

        if (!ok)
        begin
            res_next[0] = '{KIND_STATUS, STS_INVALID, OC_NONE, CA_READY, exp_reg, exp_reg,
                            64'd0, 64'd0, 64'd0, 3'd0, 1'b1};
        end
        else if (in_mode_reg == MODE_METRICS)
        begin
            // report counters and impaired time including the open interval
            res_next[0] = '{KIND_METRIC, STS_OK, OC_NONE, CA_READY, exp_reg, exp_reg,
                            64'd0, dropped_reg, 64'd0, 3'd0, 1'b0};
            res_next[1] = '{KIND_METRIC, STS_OK, OC_NONE, CA_READY, exp_reg, exp_reg,
                            64'd1, gaps_reg, 64'd0, 3'd0, 1'b0};
            res_next[2] = '{KIND_METRIC, STS_OK, OC_NONE, CA_READY, exp_reg, exp_reg,
                            64'd2, blocked_reg, 64'd0, 3'd0, 1'b0};
            res_next[3] = '{KIND_METRIC, STS_OK, OC_NONE, CA_READY, exp_reg, exp_reg,
                            64'd3,
                            imp_open_reg ? sat_add(imp_total_reg, span) : imp_total_reg,
                            64'd0, 3'd0, 1'b1};
            cnt_next = 3'd4;
        end
        else if (in_mode_reg != MODE_ADMIT)
        begin
            // lifecycle event
            case (in_mode_reg)
                MODE_LEASE:   tgt = (link_reg == ST_ACTIVE) ? ST_DEGRADED : link_reg;
                MODE_RECFAIL: tgt = ST_FAILED;
                MODE_RECOVER: tgt = ST_ACTIVE;
                MODE_UNBIND:  tgt = ST_UNBOUND;
                default:      tgt = ST_ACTIVE;
            endcase
            if (in_mode_reg == MODE_REBIND)
            begin
                exp_next = in_cur_reg;
            end
            last_time_next = in_now_reg;
            res_next[0] = '{KIND_STATUS, STS_OK, OC_NONE, CA_READY, exp_reg,
                            (in_mode_reg == MODE_REBIND) ? in_cur_reg : exp_reg,
                            64'd0, 64'd0, 64'd0, 3'd0, 1'b1};
        end
        else
        begin
            // admission
            if (link_reg == ST_UNBOUND)
            begin
                oc = OC_BYPASS;
                ca = CA_UNBOUND;
            end
            else if (topology_reg == TOPO_STRONG)
            begin
                unavail = 1'b1;
                if (link_reg == ST_FAILED)
                begin
                    ca = CA_RECFAIL;
                end
                else if (link_reg == ST_DEGRADED)
                begin
                    ca = CA_DEGRADED;
                end
                else if (in_cur_reg != exp_reg)
                begin
                    tgt = ST_DEGRADED;
                    ca  = CA_LAG;
                end
                else if (in_full_reg)
                begin
                    ca = CA_FULL;
                end
                else
                begin
                    unavail = 1'b0;
                end
                if (unavail)
                begin
                    after = exp_reg;
                    if ((link_reg == ST_FAILED) || fail_full_reg)
                    begin
                        tgt = ST_FAILED;
                        oc  = OC_FAIL;
                        st  = (ca == CA_FULL) ? STS_EXHAUST : STS_UNAVAIL;
                    end
                    else
                    begin
                        oc = OC_BLOCK;
                        st = STS_BLOCK;
                        blocked_next = sat_add(blocked_reg, 64'd1);
                    end
                end
            end
            else if (impaired_state(link_reg))
            begin
                oc       = OC_DROP;
                st       = STS_DEGRADED;
                ca       = (link_reg == ST_FAILED) ? CA_RECFAIL : CA_DEGRADED;
                g0_on    = 1'b1;
                g0_end   = in_cur_reg + 64'd1;
                g0_cause = base;
            end
            else
            begin
                if (in_cur_reg > exp_reg)
                begin
                    ca    = CA_LAG;
                    st    = STS_DEGRADED;
                    g0_on = 1'b1;
                end
                if (in_full_reg)
                begin
                    oc    = OC_DROP;
                    ca    = CA_FULL;
                    st    = STS_DEGRADED;
                    g1_on = 1'b1;
                    if (fail_full_reg)
                    begin
                        tgt = ST_FAILED;
                    end
                end
            end

            // gap debt bookkeeping
            id1      = (debt_reg == ONES) ? ONES : (debt_reg + 64'd1);
            ngap     = {1'b0, g0_on} + {1'b0, g1_on};
            gap_sum  = {1'b0, debt_reg} + {63'd0, ngap};
            debt_next = gap_sum[64] ? ONES : gap_sum[63:0];
            gap_sum  = {1'b0, gaps_reg} + {63'd0, ngap};
            gaps_next = gap_sum[64] ? ONES : gap_sum[63:0];
            drop_sum = {2'b0, dropped_reg}
                     + (g0_on ? {2'b0, g0_end - g0_first} : 66'd0)
                     + (g1_on ? 66'd1 : 66'd0);
            dropped_next = (drop_sum[65:64] != 2'b00) ? ONES : drop_sum[63:0];

            exp_next       = after;
            last_time_next = in_now_reg;
            res_next[0] = '{KIND_STATUS, st, oc, ca, exp_reg, after,
                            64'd0, 64'd0, 64'd0, 3'd0, (ngap == 2'd0)};
            if (g0_on)
            begin
                res_next[1] = '{KIND_GAP, st, oc, ca, exp_reg, after,
                                debt_reg, g0_first, g0_end, g0_cause, !g1_on};
                if (g1_on)
                begin
                    res_next[2] = '{KIND_GAP, st, oc, ca, exp_reg, after,
                                    id1, g1_first, g1_end, g1_cause, 1'b1};
                end
            end
            else if (g1_on)
            begin
                res_next[1] = '{KIND_GAP, st, oc, ca, exp_reg, after,
                                debt_reg, g1_first, g1_end, g1_cause, 1'b1};
            end
            cnt_next = {1'b0, ngap} + 3'd1;
        end

        // impaired interval tracking on a state change
        if (tgt != link_reg)
        begin
            if (!impaired_state(link_reg) && impaired_state(tgt))
            begin
                imp_open_next  = 1'b1;
                imp_since_next = in_now_reg;
            end
            else if (impaired_state(link_reg) && !impaired_state(tgt) && imp_open_reg)
            begin
                imp_total_next = sat_add(imp_total_reg, span);
                imp_open_next  = 1'b0;
                imp_since_next = 64'd0;
            end
        end
        link_next = tgt;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg     <= TOPO_STRONG;
            fail_full_reg    <= 1'b0;
            start_cursor_reg <= 64'd0;
            start_time_reg   <= 64'd0;
            link_reg         <= ST_ACTIVE;
            exp_reg          <= 64'd0;
            last_time_reg    <= 64'd0;
            debt_reg         <= 64'd0;
            dropped_reg      <= 64'd0;
            gaps_reg         <= 64'd0;
            blocked_reg      <= 64'd0;
            imp_total_reg    <= 64'd0;
            imp_open_reg     <= 1'b0;
            imp_since_reg    <= 64'd0;
            in_vld_reg       <= 1'b0;
            cnt_reg          <= 3'd0;
            idx_reg          <= 2'd0;
        end
        else
        begin
            // hold or load the input register
            if (s_tvalid && s_tready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_vld_reg <= 1'b0;
            end

            // advance the result buffer
            if (consume)
            begin
                cnt_reg <= cnt_next;
                idx_reg <= 2'd0;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                idx_reg <= idx_reg + 2'd1;
            end

            // register writes (user: only while idle, unchecked); else path state
            if (cfg_wr)
            begin
                unique case (paddr[4:3])
                    REG_TOPOLOGY: topology_reg <= pwdata[1:0];
                    REG_FAILFULL: fail_full_reg <= pwdata[0];
                    REG_CURSOR:
                    begin
                        start_cursor_reg <= pwdata;
                        exp_reg          <= pwdata;
                    end
                    REG_TIME:
                    begin
                        start_time_reg <= pwdata;
                        last_time_reg  <= pwdata;
                    end
                    default: ;
                endcase
            end
            else if (consume)
            begin
                link_reg      <= link_next;
                exp_reg       <= exp_next;
                last_time_reg <= last_time_next;
                debt_reg      <= debt_next;
                dropped_reg   <= dropped_next;
                gaps_reg      <= gaps_next;
                blocked_reg   <= blocked_next;
                imp_total_reg <= imp_total_next;
                imp_open_reg  <= imp_open_next;
                imp_since_reg <= imp_since_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_now_reg  <= s_tdata[63:0];
            in_cur_reg  <= s_tdata[127:64];
            in_full_reg <= s_tdata[128];
        end
        if (consume)
        begin
            for (int i = 0; i < RES_DEPTH; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/recorder_admission_gap_tracker_unit_tb.sv @@
// Testbench: recorder admission gap tracker, predicted results checked per field
`timescale 1ns / 1ps
`default_nettype none
module recorder_admission_gap_tracker_unit_tb;
    import ragt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 40;

    typedef struct {
        mode_t       mode;
        logic [63:0] now;
        logic [63:0] cur;
        logic        full;
    } request_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // now_time[63:0], offered_cursor[127:64], sink_full[128], pad
    logic [2:0]   s_tuser;   // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [335:0] m_tdata;   // status, outcome, cause, prior cursor, new cursor, tag,
                             // first_value, end_value, gap_cause, pad
    logic [1:0]   m_tuser;   // kind
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    recorder_admission_gap_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of configuration and state
    topo_t       cfg_topology;
    logic        cfg_fail_on_full;
    link_state_t link;
    logic [63:0] exp_cursor;
    logic [63:0] last_stamp;
    logic [63:0] debt_number;
    logic [63:0] dropped_total;
    logic [63:0] gap_total;
    logic [63:0] blocked_total;
    logic [63:0] impaired_sum;
    logic        impaired_running;
    logic [63:0] impaired_start;

    request_t    pending_requests[$];
    result_t     expected_results[$];
    result_t     debts[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          quiet_cycles;
    logic [63:0] gen_time;
    logic [63:0] gen_cursor;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[64] ? ONES : sum[63:0];
    endfunction

    function automatic logic link_impaired(input link_state_t s);
        return (s == ST_DEGRADED) || (s == ST_FAILED);
    endfunction

    function automatic logic [63:0] impaired_span(input logic [63:0] now);
        return (now >= impaired_start) ? now - impaired_start : 64'd0;
    endfunction

    // Move the link state and open or close the impaired interval
    task automatic move_link(input link_state_t s, input logic [63:0] now);
        if (s != link)
        begin
            if (!link_impaired(link) && link_impaired(s))
            begin
                impaired_running = 1'b1;
                impaired_start   = now;
            end
            else if (link_impaired(link) && !link_impaired(s) && impaired_running)
            begin
                impaired_sum     = add_sat(impaired_sum, impaired_span(now));
                impaired_running = 1'b0;
                impaired_start   = '0;
            end
            link = s;
        end
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [2:0] st,
                               input logic [2:0] oc, input logic [2:0] ca,
                               input logic [63:0] cb, input logic [63:0] cf,
                               input logic [63:0] tag, input logic [63:0] fv,
                               input logic [63:0] ev, input logic [2:0] gc,
                               input logic last);
        result_t r;
        r.kind = kind; r.status = st; r.outcome = oc; r.cause = ca;
        r.cur_old = cb; r.cur_new = cf; r.tag = tag;
        r.first_value = fv; r.end_value = ev; r.gap_cause = gc; r.last = last;
        expected_results.insert(expected_results.size(), r);
    endtask

    // Record one gap debt unless it is empty
    task automatic add_debt(input logic [63:0] first, input logic [63:0] last_excl,
                            input logic [2:0] gc);
        result_t r;
        if (first != last_excl)
        begin
            r = '0;
            r.tag = debt_number; r.first_value = first; r.end_value = last_excl;
            r.gap_cause = gc;
            debts.insert(debts.size(), r);
            if (debt_number != ONES)
                debt_number = debt_number + 1;
            dropped_total = add_sat(dropped_total, last_excl - first);
            gap_total     = add_sat(gap_total, 64'd1);
        end
    endtask

    // Work out the results of one accepted request
    task automatic predict_decision(input request_t rq);
        logic [63:0] prior_cursor;
        logic [63:0] after;
        logic [63:0] metric[4];
        logic        ok;
        logic        unavail;
        logic [2:0]  st;
        logic [2:0]  oc;
        logic [2:0]  ca;
        logic [2:0]  base;
        prior_cursor = exp_cursor;
        ok = rq.now >= last_stamp;
        if (ok)
        begin
            case (rq.mode)
                MODE_ADMIT:   ok = (rq.cur != ONES) && (rq.cur >= exp_cursor);
                MODE_LEASE, MODE_RECFAIL, MODE_UNBIND: ok = (link != ST_UNBOUND);
                MODE_RECOVER: ok = link_impaired(link);
                MODE_REBIND:  ok = (link == ST_UNBOUND) && (rq.cur != ONES);
                MODE_METRICS: ok = 1'b1;
                default:      ok = 1'b0;
            endcase
        end
        if (!ok)
        begin
            push_result(KIND_STATUS, STS_INVALID, OC_NONE, CA_READY, prior_cursor,
                        prior_cursor, '0, '0, '0, '0, 1'b1);
            return;
        end
        if (rq.mode == MODE_METRICS)
        begin
            metric[0] = dropped_total;
            metric[1] = gap_total;
            metric[2] = blocked_total;
            metric[3] = impaired_running ? add_sat(impaired_sum, impaired_span(rq.now))
                                         : impaired_sum;
            for (int i = 0; i < 4; i++)
                push_result(KIND_METRIC, STS_OK, OC_NONE, CA_READY, prior_cursor,
                            prior_cursor, 64'(i), metric[i], '0, '0, i == 3);
            return;
        end
        if (rq.mode != MODE_ADMIT)
        begin
            case (rq.mode)
                MODE_LEASE:   if (link == ST_ACTIVE) move_link(ST_DEGRADED, rq.now);
                MODE_RECFAIL: move_link(ST_FAILED, rq.now);
                MODE_RECOVER: move_link(ST_ACTIVE, rq.now);
                MODE_UNBIND:  move_link(ST_UNBOUND, rq.now);
                default:
                begin
                    exp_cursor = rq.cur;
                    move_link(ST_ACTIVE, rq.now);
                end
            endcase
            last_stamp = rq.now;
            push_result(KIND_STATUS, STS_OK, OC_NONE, CA_READY, prior_cursor, exp_cursor,
                        '0, '0, '0, '0, 1'b1);
            return;
        end
        // Admission
        debts.delete();
        st = STS_OK; oc = OC_RECORD; ca = CA_READY;
        after = rq.cur + 64'd1;
        if (link == ST_UNBOUND)
        begin
            oc = OC_BYPASS; ca = CA_UNBOUND;
        end
        else if (cfg_topology == TOPO_STRONG)
        begin
            unavail = 1'b1;
            if (link == ST_FAILED)
                ca = CA_RECFAIL;
            else if (link == ST_DEGRADED)
                ca = CA_DEGRADED;
            else if (rq.cur != exp_cursor)
            begin
                move_link(ST_DEGRADED, rq.now);
                ca = CA_LAG;
            end
            else if (rq.full)
                ca = CA_FULL;
            else
                unavail = 1'b0;
            if (unavail)
            begin
                after = exp_cursor;
                if (link == ST_FAILED || cfg_fail_on_full)
                begin
                    move_link(ST_FAILED, rq.now);
                    oc = OC_FAIL;
                    st = (ca == CA_FULL) ? STS_EXHAUST : STS_UNAVAIL;
                end
                else
                begin
                    oc = OC_BLOCK; st = STS_BLOCK;
                    blocked_total = add_sat(blocked_total, 64'd1);
                end
            end
        end
        else
        begin
            base = (cfg_topology == TOPO_ISOLATED) ? 3'd0 : 3'd3;
            if (link_impaired(link))
            begin
                oc = OC_DROP; st = STS_DEGRADED;
                ca = (link == ST_FAILED) ? CA_RECFAIL : CA_DEGRADED;
                add_debt(exp_cursor, rq.cur + 64'd1, base);
            end
            else
            begin
                if (rq.cur > exp_cursor)
                begin
                    ca = CA_LAG; st = STS_DEGRADED;
                    add_debt(exp_cursor, rq.cur, base + 3'd1);
                end
                if (rq.full)
                begin
                    oc = OC_DROP; ca = CA_FULL; st = STS_DEGRADED;
                    add_debt(rq.cur, rq.cur + 64'd1, base + 3'd2);
                    if (cfg_fail_on_full)
                        move_link(ST_FAILED, rq.now);
                end
            end
        end
        exp_cursor = after;
        last_stamp = rq.now;
        push_result(KIND_STATUS, st, oc, ca, prior_cursor, after, '0, '0, '0, '0,
                    debts.size() == 0);
        for (int i = 0; i < debts.size(); i++)
            push_result(KIND_GAP, st, oc, ca, prior_cursor, after, debts[i].tag,
                        debts[i].first_value, debts[i].end_value, debts[i].gap_cause,
                        i == debts.size() - 1);
    endtask

    // Drive request transfers from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rq = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, rq.full, rq.cur, rq.now};
                s_tuser  <= rq.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the result side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check results, then predict from accepted requests
    always @(posedge clk)
    begin
        result_t  got;
        result_t  want;
        request_t rq;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind          = m_tuser;
                got.status        = m_tdata[2:0];
                got.outcome       = m_tdata[5:3];
                got.cause         = m_tdata[8:6];
                got.cur_old       = m_tdata[72:9];
                got.cur_new       = m_tdata[136:73];
                got.tag           = m_tdata[200:137];
                got.first_value   = m_tdata[264:201];
                got.end_value     = m_tdata[328:265];
                got.gap_cause     = m_tdata[331:329];
                got.last          = m_tlast;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected result: expected none, actual %p", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        error_count++;
                        $display("%0t result mismatch: expected %p, actual %p",
                                 $time, want, got);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq.mode = mode_t'(s_tuser);
                rq.now  = s_tdata[63:0];
                rq.cur  = s_tdata[127:64];
                rq.full = s_tdata[128];
                predict_decision(rq);
            end
        end
    end

    // Watchdog: count stuck cycles while work is outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // Register write: setup cycle then access cycle; update predictor copy
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOPOLOGY: cfg_topology = topo_t'(value[1:0]);
            REG_FAILFULL: cfg_fail_on_full = value[0];
            REG_CURSOR:   exp_cursor = value;
            default:      last_stamp = value;
        endcase
    endtask

    task automatic queue_request(input mode_t md, input logic [63:0] now,
                                 input logic [63:0] cur, input logic full);
        request_t rq;
        rq.mode = md; rq.now = now; rq.cur = cur; rq.full = full;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    // Mostly well-formed traffic near the tracked time and cursor
    task automatic queue_random_request();
        int          pick;
        logic [63:0] now;
        logic [63:0] cur;
        mode_t       md;
        pick = $urandom_range(99);
        if (gen_time <= ONES - 64'd64)
            gen_time = gen_time + 64'($urandom_range(40));
        now = gen_time;
        if ($urandom_range(99) < 5 && gen_time > 64'd10)
            now = gen_time - 64'($urandom_range(10, 1));
        cur = gen_cursor;
        if (pick < 55)
        begin
            md = MODE_ADMIT;
            if ($urandom_range(99) < 40)
                cur = gen_cursor + 64'($urandom_range(4, 1));
            else if ($urandom_range(99) < 8 && gen_cursor != 0)
                cur = gen_cursor - 64'd1;
            if (cur >= gen_cursor)
                gen_cursor = cur + 64'd1;
        end
        else if (pick < 90)
        begin
            md = mode_t'($urandom_range(5, 1));
            if (md == MODE_REBIND)
            begin
                cur = ($urandom_range(99) < 5) ? ONES : gen_cursor + 64'($urandom_range(50));
                if (cur != ONES)
                    gen_cursor = cur;
            end
        end
        else if (pick < 97)
            md = MODE_METRICS;
        else
            md = MODE_SPARE;
        queue_request(md, now, cur, $urandom_range(99) < 25);
    endtask

    // Stimulus
    initial
    begin
        logic [63:0] phase_cursor;
        logic [63:0] phase_time;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        send_idle_pct = 10;
        recv_idle_pct = 86;
        error_count   = 0;
        quiet_cycles  = 0;
        cfg_topology     = TOPO_STRONG;
        cfg_fail_on_full = 1'b0;
        link             = ST_ACTIVE;
        exp_cursor       = '0;
        last_stamp       = '0;
        debt_number      = '0;
        dropped_total    = '0;
        gap_total        = '0;
        blocked_total    = '0;
        impaired_sum     = '0;
        impaired_running = 1'b0;
        impaired_start   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: strong topology from reset values
        queue_request(MODE_ADMIT,   64'd0,  64'd0, 1'b0);   // record
        queue_request(MODE_ADMIT,   64'd5,  64'd1, 1'b1);   // full sink blocks
        queue_request(MODE_ADMIT,   64'd6,  64'd1, 1'b0);
        queue_request(MODE_ADMIT,   64'd7,  64'd5, 1'b0);   // cursor lag degrades
        queue_request(MODE_METRICS, 64'd8,  64'd0, 1'b0);
        queue_request(MODE_RECOVER, 64'd9,  64'd0, 1'b0);
        queue_request(MODE_ADMIT,   64'd3,  64'd2, 1'b0);   // stale time
        queue_request(MODE_ADMIT,   64'd10, 64'd0, 1'b0);   // stale cursor
        queue_request(MODE_ADMIT,   64'd10, ONES,  1'b0);   // all-ones cursor
        queue_request(MODE_LEASE,   64'd11, 64'd0, 1'b0);
        queue_request(MODE_RECFAIL, 64'd12, 64'd0, 1'b0);
        queue_request(MODE_ADMIT,   64'd13, 64'd2, 1'b1);   // failed recorder
        queue_request(MODE_RECOVER, 64'd14, 64'd0, 1'b0);
        queue_request(MODE_UNBIND,  64'd15, 64'd0, 1'b0);
        queue_request(MODE_ADMIT,   64'd16, 64'd9, 1'b1);   // bypass while unbound
        queue_request(MODE_LEASE,   64'd16, 64'd0, 1'b0);   // rejected while unbound
        queue_request(MODE_UNBIND,  64'd16, 64'd0, 1'b0);   // rejected while unbound
        queue_request(MODE_REBIND,  64'd17, ONES,  1'b0);   // all-ones rebind cursor
        queue_request(MODE_REBIND,  64'd17, 64'd100, 1'b0);
        queue_request(MODE_SPARE,   64'd18, 64'd100, 1'b0); // unused mode
        queue_request(MODE_RECOVER, 64'd18, 64'd0, 1'b0);   // recover while active
        queue_request(MODE_METRICS, ONES,   64'd0, 1'b0);
        queue_request(MODE_ADMIT,   ONES,   ONES - 64'd1, 1'b1);
        queue_request(MODE_METRICS, ONES,   64'd0, 1'b0);
        wait_drained();
        repeat (4) @(posedge clk);

        // Random phases over topology, fail-on-full and start values
        for (int phase = 0; phase < 7; phase++)
        begin
            send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 86 : 0;
            recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 10 : 0;
            phase_cursor = {32'd0, $urandom};
            phase_time   = {24'd0, $urandom, 8'd0};
            case (phase)
                1: phase_cursor = '0;
                2: phase_cursor = ONES - 64'd1;
                3: phase_time   = ONES - 64'd2000;
                4: phase_time   = '0;
                default: ;
            endcase
            write_reg(REG_TOPOLOGY, 64'(phase % 4));
            write_reg(REG_FAILFULL, 64'((phase / 2) % 2));
            write_reg(REG_CURSOR, phase_cursor);
            write_reg(REG_TIME, phase_time);
            gen_cursor = phase_cursor;
            gen_time   = phase_time;
            // Fail then recover so a bound link starts active
            queue_request(MODE_RECFAIL, gen_time, '0, 1'b0);
            queue_request(MODE_RECOVER, gen_time, '0, 1'b0);
            for (int i = 0; i < PHASE_ITEMS - 6; i++)
            begin
                queue_random_request();
                if (phase == 3 && i == 15)
                    wait_drained();
            end
            // Noise with full-range fields
            for (int i = 0; i < 4; i++)
                queue_request(mode_t'($urandom_range(7)), {$urandom, $urandom},
                              {$urandom, $urandom}, $urandom_range(1));
            wait_drained();
            repeat (4) @(posedge clk);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
